FILE: design/gspc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gspc_pkg: shared types and constants of the gas sensor ppm converter
// Widths, fixed-point constants, register map, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gspc_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int MAX_SAMPLES  = 64;
    localparam int COUNT_W      = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W        = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int VOL_MULT     = 5 * (2 ** (16 - SAMPLE_BITS));
    localparam int SCALED_W     = SUM_W + $clog2(VOL_MULT + 1);

    localparam int VOL_W        = 19;
    localparam int DIFF_W       = 19;
    localparam int P1_W         = 40;
    localparam int HALF_W       = 20;
    localparam int PART_W       = HALF_W + VOL_W;
    localparam int NUM_W        = 59;
    localparam int DEN_W        = 28;
    localparam int QUOT_W       = 34;
    localparam int STEP_W       = $clog2(QUOT_W + 1);
    localparam int LOG_W        = 24;
    localparam int PROD_W       = 42;
    localparam int Z_W          = 26;
    localparam int IP_W         = 10;
    localparam int PPM_W        = 20;

    localparam logic [VOL_W-1:0]  VOL_MIN_Q16    = 19'd655;
    localparam logic [VOL_W-1:0]  FIVE_Q16       = 19'd327680;
    localparam logic [PPM_W-1:0]  PPM_MAX        = 20'hFFFFF;
    localparam int                LOG_OFFSET_Q16 = 3800;
    localparam int                LOG_BIAS       = 17;

    localparam logic [6:0]  RST_SAMPLES  = 7'd10;
    localparam logic [15:0] RST_BASELINE = 16'd1700;
    localparam logic [23:0] RST_SCALE    = 24'd756469;
    localparam logic [17:0] RST_EXPONENT = 18'd42920;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SAMPLES  = 2'd0,
        REG_BASELINE = 2'd1,
        REG_SCALE    = 2'd2,
        REG_EXPONENT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [6:0]  samples_per_reading;
        logic [15:0] baseline_resistance_q8;
        logic [23:0] curve_scale_q16;
        logic [17:0] curve_exponent_q16;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VOL_DIV,
        S_MUL1,
        S_MUL2,
        S_X_START,
        S_X_DIV,
        S_NORM,
        S_LOG,
        S_EXP,
        S_OUT
    } t_state;

    typedef struct packed {
        logic acc;
        logic vol_start;
        logic vol_capture;
        logic mul1;
        logic mul2;
        logic x_start;
        logic x_capture;
        logic norm_step;
        logic zero_result;
        logic log_mult;
        logic exp_calc;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic last;
        logic div_done;
        logic x_zero;
        logic norm_done;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

FILE: design/gas_sensor_ppm_converter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_top: gas concentration converter
// Input channel (i_valid / o_ready / i_sample): one converter sample per
// transaction. Each accepted sample is added to the sum. The sample that
// completes a reading (samples_per_reading, clamped to 1..64) starts the
// conversion: voltage divide, two multiply steps, a divide start step,
// ratio divide (cut short when the ratio saturates), normalization (cut
// short when the ratio is zero or saturated), log-multiply, exp and output
// load. The shared divider makes one quotient bit per cycle and the
// normalizer shifts one bit per cycle. o_ready is low during a conversion.
// Output channel (o_valid / i_ready / o_ppm_q8, o_voltage_clamped,
// o_saturated): one transaction per reading, held in an output register.
// While the receiver stalls, samples of the next reading are still taken;
// a conversion that finishes before the held transaction is taken waits in
// its last step with o_ready low.
// APB port: registers at byte addresses 0, 4, 8, 12; pready is always high.
// Reset (synchronous, active low) clears sum, count, sequencer and output
// valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter_top
    import gspc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [PPM_W-1:0]       o_ppm_q8,
    output logic                        o_voltage_clamped,
    output logic                        o_saturated,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [ADDR_W-1:0]      paddr,
    input  wire logic [DATA_W-1:0]      pwdata,
    output logic      [DATA_W-1:0]      prdata,
    output logic                        pready
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    gspc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gspc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    gspc_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_sample          (i_sample),
        .o_out_valid       (o_valid),
        .i_out_ready       (i_ready),
        .o_ppm_q8          (o_ppm_q8),
        .o_voltage_clamped (o_voltage_clamped),
        .o_saturated       (o_saturated)
    );

endmodule
`default_nettype wire

FILE: design/gspc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gspc_cfg: configuration registers
// APB-style register file holding sample count, baseline resistance,
// curve scale and curve exponent.
// ----------------------------------------------------------------------------
module gspc_cfg
    import gspc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0] pwdata,
    output logic      [DATA_W-1:0] prdata,
    output logic                   pready,
    output t_cfg                   o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en   = psel & penable & pwrite & pready;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.samples_per_reading    <= RST_SAMPLES;
            r_cfg.baseline_resistance_q8 <= RST_BASELINE;
            r_cfg.curve_scale_q16        <= RST_SCALE;
            r_cfg.curve_exponent_q16     <= RST_EXPONENT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SAMPLES:  r_cfg.samples_per_reading    <= pwdata[6:0];
                REG_BASELINE: r_cfg.baseline_resistance_q8 <= pwdata[15:0];
                REG_SCALE:    r_cfg.curve_scale_q16        <= pwdata[23:0];
                REG_EXPONENT: r_cfg.curve_exponent_q16     <= pwdata[17:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAMPLES:  prdata = {25'd0, r_cfg.samples_per_reading};
            REG_BASELINE: prdata = {16'd0, r_cfg.baseline_resistance_q8};
            REG_SCALE:    prdata = {8'd0, r_cfg.curve_scale_q16};
            REG_EXPONENT: prdata = {14'd0, r_cfg.curve_exponent_q16};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: design/gspc_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gspc_div: shared bit-serial divider
// Restoring division, one quotient bit per cycle, quotient saturated to
// QUOT_W bits when the true quotient does not fit.
// ----------------------------------------------------------------------------
module gspc_div
    import gspc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [NUM_W-1:0]  i_num,
    input  wire logic [DEN_W-1:0]  i_den,
    output logic                   o_done,
    output logic      [QUOT_W-1:0] o_quot
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_num;
    logic [QUOT_W-1:0] r_quot;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic [DEN_W-1:0]  num_hi;

    assign num_hi    = DEN_W'(i_num[NUM_W-1:QUOT_W]);
    assign trial     = {r_rem, r_num[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign o_done    = r_done;
    assign o_quot    = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (num_hi >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_step <= STEP_W'(QUOT_W);
                end
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_den;
            r_rem  <= num_hi;
            r_num  <= i_num[QUOT_W-1:0];
            r_quot <= '1;
        end else if (r_busy) begin
            r_num <= {r_num[QUOT_W-2:0], 1'b0};
            if (!trial_sub[DEN_W]) begin
                r_rem  <= trial_sub[DEN_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= trial[DEN_W-1:0];
                r_quot <= {r_quot[QUOT_W-2:0], 1'b0};
            end
        end
    end

`ifndef SYNTH
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
`endif

endmodule
`default_nettype wire

FILE: design/gspc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gspc_datapath: accumulation, voltage, ratio, log and exp datapath
// Sums samples, forms the averaged voltage and resistance ratio through the
// shared divider, then the Mitchell log2 / exponent / piecewise exp2 chain,
// and holds the result in the output register.
// ----------------------------------------------------------------------------
module gspc_datapath
    import gspc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [PPM_W-1:0]       o_ppm_q8,
    output logic                        o_voltage_clamped,
    output logic                        o_saturated
);

    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic [VOL_W-1:0]    r_vol;
    logic [DIFF_W-1:0]   r_diff;
    logic                r_clamped;
    logic [P1_W-1:0]     r_p1;
    logic [PART_W-1:0]   r_pl;
    logic [PART_W-1:0]   r_ph;
    logic [QUOT_W-1:0]   r_xn;
    logic [STEP_W-1:0]   r_lz;
    logic signed [PROD_W-1:0] r_prod;
    logic [PPM_W-1:0]    r_ppm;
    logic                r_sat;
    logic                r_out_valid;
    logic [PPM_W-1:0]    r_out_ppm;
    logic                r_out_clamped;
    logic                r_out_sat;

    logic [COUNT_W-1:0]  n_eff;
    logic [SUM_W-1:0]    sum_next;
    logic [COUNT_W-1:0]  cnt_next;
    logic [SCALED_W-1:0] sum_scaled;
    logic                div_start;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [QUOT_W-1:0]   div_quot;
    logic                vol_low;
    logic [VOL_W-1:0]    vol_sel;
    logic [DIFF_W-1:0]   diff_sel;
    logic [P1_W-1:0]     p1_c;
    logic [PART_W-1:0]   pl_c;
    logic [PART_W-1:0]   ph_c;
    logic signed [7:0]   log_int;
    logic signed [LOG_W-1:0] log_val;
    logic signed [17:0]  exp_s;
    logic signed [PROD_W-1:0] prod_c;
    logic signed [PROD_W-1:0] prod_adj;
    logic signed [Z_W-1:0]    z_val;
    logic signed [Z_W-1:0]    w_val;
    logic signed [IP_W-1:0]   ip;
    logic signed [IP_W-1:0]   sh_full;
    logic [16:0]         mant;
    logic [PPM_W-1:0]    ppm_c;
    logic                sat_c;

    always_comb begin
        if (i_cfg.samples_per_reading == 7'd0) begin
            n_eff = COUNT_W'(1);
        end else if (32'(i_cfg.samples_per_reading) > MAX_SAMPLES) begin
            n_eff = COUNT_W'(MAX_SAMPLES);
        end else begin
            n_eff = COUNT_W'(i_cfg.samples_per_reading);
        end
    end

    assign sum_next   = r_sum + SUM_W'(i_sample);
    assign cnt_next   = r_count + 1'b1;
    assign sum_scaled = SCALED_W'(sum_next) * SCALED_W'(VOL_MULT);

    assign div_start = i_cmd.vol_start | i_cmd.x_start;
    assign div_num   = i_cmd.x_start ? ({r_ph, {HALF_W{1'b0}}} + NUM_W'(r_pl))
                                     : NUM_W'(sum_scaled);
    assign div_den   = i_cmd.x_start ? {r_diff, 9'd0} : DEN_W'(cnt_next);

    gspc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign vol_low  = div_quot < QUOT_W'(VOL_MIN_Q16);
    assign vol_sel  = vol_low ? VOL_MIN_Q16 : div_quot[VOL_W-1:0];
    assign diff_sel = (vol_sel < FIVE_Q16) ? (FIVE_Q16 - vol_sel) : DIFF_W'(1);

    assign p1_c = {16'd0, i_cfg.curve_scale_q16} * {24'd0, i_cfg.baseline_resistance_q8};
    assign pl_c = {{VOL_W{1'b0}}, r_p1[HALF_W-1:0]} * {{HALF_W{1'b0}}, r_vol};
    assign ph_c = {{VOL_W{1'b0}}, r_p1[P1_W-1:HALF_W]} * {{HALF_W{1'b0}}, r_vol};

    assign log_int = 8'(LOG_BIAS) - 8'(r_lz);
    assign log_val = $signed({log_int, r_xn[QUOT_W-2:QUOT_W-17]})
                     + LOG_W'(LOG_OFFSET_Q16);
    assign exp_s   = $signed(i_cfg.curve_exponent_q16);
    assign prod_c  = exp_s * log_val;

    assign prod_adj = r_prod + (r_prod[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
    assign z_val    = prod_adj[PROD_W-1:16];
    assign w_val    = z_val - Z_W'(LOG_OFFSET_Q16);
    assign ip       = w_val[Z_W-1:16];
    assign mant     = {1'b1, w_val[15:0]};
    assign sh_full  = IP_W'(8) - ip;

    always_comb begin
        sat_c = 1'b0;
        if (ip >= IP_W'(12)) begin
            ppm_c = PPM_MAX;
            sat_c = 1'b1;
        end else if (ip >= IP_W'(8)) begin
            ppm_c = PPM_W'(mant) << ip[1:0];
        end else if (ip >= -IP_W'(8)) begin
            ppm_c = PPM_W'(mant >> sh_full[4:0]);
        end else begin
            ppm_c = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (i_cmd.acc) begin
            if (o_status.last) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_next;
                r_count <= cnt_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vol_capture) begin
            r_vol     <= vol_sel;
            r_diff    <= diff_sel;
            r_clamped <= vol_low;
        end
        if (i_cmd.mul1) begin
            r_p1 <= p1_c;
        end
        if (i_cmd.mul2) begin
            r_pl <= pl_c;
            r_ph <= ph_c;
        end
        if (i_cmd.x_capture) begin
            r_xn <= div_quot;
            r_lz <= '0;
        end else if (i_cmd.norm_step) begin
            r_xn <= {r_xn[QUOT_W-2:0], 1'b0};
            r_lz <= r_lz + 1'b1;
        end
        if (i_cmd.log_mult) begin
            r_prod <= prod_c;
        end
        if (i_cmd.zero_result) begin
            r_ppm <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.exp_calc) begin
            r_ppm <= ppm_c;
            r_sat <= sat_c;
        end
        if (i_cmd.out_load) begin
            r_out_ppm     <= r_ppm;
            r_out_clamped <= r_clamped;
            r_out_sat     <= r_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_status.last      = cnt_next >= n_eff;
    assign o_status.div_done  = div_done;
    assign o_status.x_zero    = r_xn == '0;
    assign o_status.norm_done = r_xn[QUOT_W-1];
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_ppm_q8          = r_out_ppm;
    assign o_voltage_clamped = r_out_clamped;
    assign o_saturated       = r_out_sat;

`ifndef SYNTH
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) < MAX_SAMPLES)
        else $error("sample count beyond the largest reading size");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a transaction not yet taken");

    a_norm_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.norm_step |-> (!r_xn[QUOT_W-1] && (r_xn != '0)))
        else $error("normalize step on zero or normalized ratio");
`endif

endmodule
`default_nettype wire

FILE: design/gspc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gspc_ctrl: conversion sequencer
// Accepts samples while idle and steps the datapath through divide,
// multiply, normalize, log and exp phases for each completed reading.
// ----------------------------------------------------------------------------
module gspc_ctrl
    import gspc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_status.last) begin
                        o_cmd.vol_start = 1'b1;
                        n_state         = S_VOL_DIV;
                    end
                end
            end
            S_VOL_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.vol_capture = 1'b1;
                    n_state           = S_MUL1;
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_X_START;
            end
            S_X_START: begin
                o_cmd.x_start = 1'b1;
                n_state       = S_X_DIV;
            end
            S_X_DIV: begin
                if (i_status.div_done) begin
                    o_cmd.x_capture = 1'b1;
                    n_state         = S_NORM;
                end
            end
            S_NORM: begin
                if (i_status.x_zero) begin
                    o_cmd.zero_result = 1'b1;
                    n_state           = S_OUT;
                end else if (i_status.norm_done) begin
                    n_state = S_LOG;
                end else begin
                    o_cmd.norm_step = 1'b1;
                end
            end
            S_LOG: begin
                o_cmd.log_mult = 1'b1;
                n_state        = S_EXP;
            end
            S_EXP: begin
                o_cmd.exp_calc = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_start_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.vol_start |=> (r_state == S_VOL_DIV))
        else $error("reading start did not enter the voltage divide");
`endif

endmodule
`default_nettype wire

FILE: verif/gas_sensor_ppm_converter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_ppm_converter_top_test: self-checking bench of the ppm converter
// Drives converter samples through the valid/ready input channel and programs
// the four registers over APB between phases. A bit-exact predictor sums the
// samples and forms each concentration reading. Every output transaction is
// compared field by field with the oldest predicted reading. Directed
// corners come first, then randomized phases with source gaps and sink
// stalls.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_converter_top_test;
    import gspc_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_ITEMS  = 94;

    typedef struct packed {
        logic [PPM_W-1:0] ppm_q8;
        logic             voltage_clamped;
        logic             saturated;
    } t_reading;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    logic [SAMPLE_BITS-1:0] i_sample = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [PPM_W-1:0]       o_ppm_q8;
    logic                   o_voltage_clamped;
    logic                   o_saturated;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [DATA_W-1:0]      pwdata = '0;
    logic [DATA_W-1:0]      prdata;
    logic                   pready;

    logic [SAMPLE_BITS-1:0] sample_queue[$];
    t_reading               reading_queue[$];
    t_reading               reading_head;
    t_cfg                   model_cfg;
    logic [31:0]            model_sum;
    logic [31:0]            model_count;

    int  src_idle_pct = 0;
    int  sink_stall_pct = 0;
    bit  hold_src = 1'b0;
    int  cycle_count = 0;
    int  error_count = 0;
    int  accepted_count = 0;
    int  reading_count = 0;
    int  clamped_count = 0;
    int  saturated_count = 0;

    gas_sensor_ppm_converter_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample          (i_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_ppm_q8          (o_ppm_q8),
        .o_voltage_clamped (o_voltage_clamped),
        .o_saturated       (o_saturated),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_reading convert_reading(logic [31:0] sum, logic [31:0] cnt);
        logic [63:0] vol;
        logic [63:0] diff;
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] mant;
        logic [63:0] v;
        longint      lg;
        longint      expo;
        longint      z;
        longint      w;
        longint      ip;
        int          p;
        int          i;
        t_reading    r;
        r = '0;
        vol = 64'(sum);
        vol = (vol * 64'd327680) / ({32'd0, cnt} << SAMPLE_BITS);
        if (vol < 64'(VOL_MIN_Q16)) begin
            vol = 64'(VOL_MIN_Q16);
            r.voltage_clamped = 1'b1;
        end
        diff = (vol < 64'(FIVE_Q16)) ? (64'(FIVE_Q16) - vol) : 64'd1;
        num = 64'(model_cfg.curve_scale_q16);
        num = num * 64'(model_cfg.baseline_resistance_q8);
        num = num * vol;
        x = num / (64'd512 * diff);
        if (x > 64'h3_FFFF_FFFF) x = 64'h3_FFFF_FFFF;
        if (x != 0) begin
            p = 0;
            for (i = 0; i < 64; i++) begin
                if (x[i]) p = i;
            end
            frac = x - (64'd1 << p);
            if (p >= 16) frac = frac >> (p - 16);
            else frac = frac << (16 - p);
            lg = longint'(p - 16);
            lg = lg * 65536 + $signed(frac) + LOG_OFFSET_Q16;
            expo = 64'($signed(model_cfg.curve_exponent_q16));
            z = (expo * lg) / 65536;
            w = z - LOG_OFFSET_Q16;
            ip = w >>> 16;
            mant = 64'd65536 + (w & 64'hFFFF);
            if (ip >= 12) begin
                r.saturated = 1'b1;
                r.ppm_q8 = PPM_MAX;
            end else begin
                if (ip >= 8) v = mant << (ip - 8);
                else v = mant >> (8 - ip);
                if (v > 64'(PPM_MAX)) begin
                    r.saturated = 1'b1;
                    r.ppm_q8 = PPM_MAX;
                end else begin
                    r.ppm_q8 = v[PPM_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic void accumulate_sample(logic [SAMPLE_BITS-1:0] s);
        logic [31:0] n;
        n = 32'(model_cfg.samples_per_reading);
        if (n < 1) n = 32'd1;
        if (n > MAX_SAMPLES) n = 32'(MAX_SAMPLES);
        model_sum = model_sum + 32'(s);
        model_count = model_count + 32'd1;
        if (model_count >= n) begin
            reading_queue.push_back(convert_reading(model_sum, model_count));
            model_sum = '0;
            model_count = '0;
        end
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SAMPLES:  model_cfg.samples_per_reading = value[6:0];
            REG_BASELINE: model_cfg.baseline_resistance_q8 = value[15:0];
            REG_SCALE:    model_cfg.curve_scale_q16 = value[23:0];
            REG_EXPONENT: model_cfg.curve_exponent_q16 = value[17:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || i_valid || reading_queue.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                accumulate_sample(i_sample);
                accepted_count++;
            end
            if (!i_valid || o_ready) begin
                if (sample_queue.size() != 0 && !hold_src &&
                    $urandom_range(99) >= src_idle_pct) begin
                    i_valid <= 1'b1;
                    i_sample <= sample_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (reading_queue.size() == 0) begin
                    if (error_count < 10)
                        $display("ERROR: unexpected reading ppm=%0d clamped=%0b sat=%0b",
                                 o_ppm_q8, o_voltage_clamped, o_saturated);
                    error_count++;
                end else begin
                    reading_head = reading_queue.pop_front();
                    reading_count++;
                    if (reading_head.voltage_clamped) clamped_count++;
                    if (reading_head.saturated) saturated_count++;
                    if (o_ppm_q8 !== reading_head.ppm_q8 ||
                        o_voltage_clamped !== reading_head.voltage_clamped ||
                        o_saturated !== reading_head.saturated) begin
                        if (error_count < 10)
                            $display("ERROR: reading %0d ppm=%0d/%0d clamped=%0b/%0b sat=%0b/%0b",
                                     reading_count, o_ppm_q8, reading_head.ppm_q8,
                                     o_voltage_clamped, reading_head.voltage_clamped,
                                     o_saturated, reading_head.saturated);
                        error_count++;
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: timeout after %0d cycles, %0d readings pending",
                     cycle_count, reading_queue.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int ph;
        int k;
        logic [DATA_W-1:0] value;
        model_cfg.samples_per_reading = RST_SAMPLES;
        model_cfg.baseline_resistance_q8 = RST_BASELINE;
        model_cfg.curve_scale_q16 = RST_SCALE;
        model_cfg.curve_exponent_q16 = RST_EXPONENT;
        model_sum = '0;
        model_count = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults, then lower the count below the partial sum
        sample_queue.push_back(12'd0);
        sample_queue.push_back(12'd4095);
        sample_queue.push_back(12'd1);
        sample_queue.push_back(12'd2048);
        drain();
        write_reg(REG_SAMPLES, 32'd2);
        sample_queue.push_back(12'd3000);
        drain();
        write_reg(REG_SAMPLES, 32'd1);
        sample_queue.push_back(12'd4095);
        sample_queue.push_back(12'd0);
        sample_queue.push_back(12'd1);
        sample_queue.push_back(12'd2048);
        sample_queue.push_back(12'd7);
        drain();
        write_reg(REG_SAMPLES, 32'd0);
        sample_queue.push_back(12'd4095);
        sample_queue.push_back(12'd0);
        drain();
        write_reg(REG_SCALE, 32'hFF_FFFF);
        write_reg(REG_BASELINE, 32'hFFFF);
        write_reg(REG_EXPONENT, 32'h1_FFFF);
        sample_queue.push_back(12'd4095);
        sample_queue.push_back(12'd0);
        drain();
        write_reg(REG_EXPONENT, 32'h2_0000);
        sample_queue.push_back(12'd4095);
        sample_queue.push_back(12'd0);
        sample_queue.push_back(12'd8);
        drain();
        write_reg(REG_SCALE, 32'd0);
        sample_queue.push_back(12'd2000);
        drain();
        write_reg(REG_SCALE, 32'd756469);
        write_reg(REG_BASELINE, 32'd0);
        sample_queue.push_back(12'd100);
        drain();
        write_reg(REG_BASELINE, 32'd1700);
        write_reg(REG_EXPONENT, 32'd0);
        sample_queue.push_back(12'd1234);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case ($urandom_range(9))
                0: value = 32'd0;
                1: value = 32'd127;
                2: value = 32'd64;
                default: value = $urandom_range(1, 8);
            endcase
            if (ph == 5) value = 32'd127;
            write_reg(REG_SAMPLES, value);
            case ($urandom_range(7))
                0: value = 32'd0;
                1: value = 32'hFFFF;
                2: value = 32'd1;
                default: value = $urandom_range(1, 65535);
            endcase
            write_reg(REG_BASELINE, value);
            case ($urandom_range(7))
                0: value = 32'd0;
                1: value = 32'hFF_FFFF;
                2: value = 32'd756469;
                default: value = $urandom_range(0, 24'hFF_FFFF);
            endcase
            write_reg(REG_SCALE, value);
            case ($urandom_range(7))
                0: value = 32'h2_0000;
                1: value = 32'h1_FFFF;
                2: value = 32'd42920;
                default: value = $urandom_range(0, 18'h3_FFFF);
            endcase
            write_reg(REG_EXPONENT, value);

            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 61; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 61; end
                default: begin src_idle_pct = 23; sink_stall_pct = 23; end
            endcase

            for (k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(9))
                    0, 1: sample_queue.push_back(12'($urandom_range(0, 12)));
                    2: sample_queue.push_back($urandom_range(1) ? 12'd4095 : 12'd0);
                    3: sample_queue.push_back(12'($urandom_range(4000, 4095)));
                    default: sample_queue.push_back(12'($urandom_range(0, 4095)));
                endcase
            end

            if (ph == 1) begin
                while (sample_queue.size() > PHASE_ITEMS / 2) @(negedge i_clk);
                hold_src = 1'b1;
                while (reading_queue.size() != 0) @(negedge i_clk);
                hold_src = 1'b0;
            end
            drain();
        end

        $display("Run covered %0d samples and %0d readings (%0d clamped, %0d saturated).",
                 accepted_count, reading_count, clamped_count, saturated_count);
        $display("Mismatches and unexpected readings: %0d", error_count);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
